// ===== rtl/clnws_pkg.sv =====
// ----------------------------------------------------------------------------
// clnws_pkg
// Shared types and constants for the character LCD nibble write sequencer.
// ----------------------------------------------------------------------------
package clnws_pkg;

  // request beat
  typedef struct packed {
    logic       func;
    logic [7:0] value;
    logic       reg_select;
  } in_item_t;

  // pin event beat
  typedef struct packed {
    logic        rs_pin;
    logic [3:0]  data_pins;
    logic        en_pin;
    logic [15:0] hold_us;
    logic        last;
  } out_item_t;

  // request codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_INIT  = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLE_PULSE = 2'd0,
    CFG_NIBBLE_SETTLE = 2'd1,
    CFG_BYTE_GAP = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_idx_t;

  // configuration reset values
  localparam logic [7:0] ENABLE_PULSE_RST  = 8'd1;
  localparam logic [9:0] NIBBLE_SETTLE_RST = 10'd50;
  localparam logic [9:0] BYTE_GAP_RST      = 10'd200;

  // power-up sequence constants
  localparam logic [15:0] INIT_WAIT_US = 16'd60000;
  localparam logic [15:0] INIT_TAIL_US = 16'd37;
  localparam logic [15:0] MODE_EXTRA_US [4] = '{16'd50000, 16'd1000, 16'd37, 16'd37};
  localparam logic [3:0]  MODE_NIBBLE [4]   = '{4'h3, 4'h3, 4'h3, 4'h2};
  localparam logic [7:0]  INIT_BYTES [4]    = '{8'h28, 8'h0F, 8'h01, 8'h06};

  // event step landmarks
  localparam logic [4:0] INIT_BYTE_BASE = 5'd9;
  localparam logic [4:0] INIT_LAST_STEP = 5'd24;
  localparam logic [4:0] BYTE_LAST_STEP = 5'd3;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       emit;
    logic [4:0] step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ev_last;
  } dp_status_t;

endpackage

// ===== rtl/clnws_ctrl.sv =====
// ----------------------------------------------------------------------------
// clnws_ctrl
// Sequencer controller: accepts requests, walks the event step counter and
// owns the output beat valid flag.
// ----------------------------------------------------------------------------
module clnws_ctrl
  import clnws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       in_fire;
  logic       out_fire;
  logic       emit;

  // handshake terms
  assign in_ready = (state_r == ST_IDLE) || (state_r == ST_DRAIN);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = ovalid_r && out_ready;
  assign emit     = (state_r == ST_RUN) && (!ovalid_r || out_ready);
  assign out_valid = ovalid_r;

  // datapath commands
  assign cmd.load = in_fire;
  assign cmd.emit = emit;
  assign cmd.step = step_r;

  // next state
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    ovalid_nxt = ovalid_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_fire) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (emit) begin
          if (status.ev_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            step_nxt = step_r + 5'd1;
          end
        end
      end
      ST_DRAIN: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end else if (out_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// ===== rtl/clnws_datapath.sv =====
// ----------------------------------------------------------------------------
// clnws_datapath
// Timing registers, held request and event decode into the output register.
// ----------------------------------------------------------------------------
module clnws_datapath
  import clnws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_fire,
  input  cfg_idx_t   cfg_index,
  input  logic [15:0] cfg_data,
  input  in_item_t   in_item,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output out_item_t  out_item
);

  logic [7:0]  enable_pulse_r;
  logic [9:0]  nibble_settle_r;
  logic [9:0]  byte_gap_r;
  logic        init_mode_r;
  logic [7:0]  held_byte_r;
  logic        held_select_r;
  out_item_t   out_r;
  out_item_t   ev;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_pulse_r  <= ENABLE_PULSE_RST;
      nibble_settle_r <= NIBBLE_SETTLE_RST;
      byte_gap_r      <= BYTE_GAP_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_ENABLE_PULSE:  enable_pulse_r  <= cfg_data[7:0];
        CFG_NIBBLE_SETTLE: nibble_settle_r <= cfg_data[9:0];
        CFG_BYTE_GAP:      byte_gap_r      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // held request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_mode_r   <= 1'b0;
      held_byte_r   <= '0;
      held_select_r <= 1'b0;
    end else if (cmd.load) begin
      init_mode_r <= (in_item.func == FUNC_INIT);
      if (in_item.func == FUNC_WRITE) begin
        held_byte_r   <= in_item.value;
        held_select_r <= in_item.reg_select;
      end
    end
  end

  // event decode for the current step
  always_comb begin
    logic [4:0]  mstep;
    logic [4:0]  bstep;
    logic [7:0]  cur_byte;
    logic [1:0]  pos;
    logic [15:0] tail;
    logic [15:0] settle_gap;
    mstep      = cmd.step - 5'd1;
    bstep      = cmd.step - INIT_BYTE_BASE;
    settle_gap = 16'(nibble_settle_r) + 16'(byte_gap_r);
    cur_byte   = held_byte_r;
    pos        = cmd.step[1:0];
    tail       = '0;
    ev         = '0;
    if (init_mode_r) begin
      cur_byte = INIT_BYTES[bstep[3:2]];
      pos      = bstep[1:0];
      tail     = INIT_TAIL_US;
    end
    ev.rs_pin    = init_mode_r ? 1'b0 : held_select_r;
    ev.data_pins = pos[1] ? cur_byte[3:0] : cur_byte[7:4];
    ev.en_pin    = ~pos[0];
    ev.hold_us   = ev.en_pin ? 16'(enable_pulse_r)
                 : (settle_gap + (pos[1] ? tail : 16'd0));
    ev.last      = init_mode_r ? (cmd.step == INIT_LAST_STEP)
                               : (cmd.step == BYTE_LAST_STEP);
    priority if (init_mode_r && cmd.step == 5'd0) begin
      // opening idle wait
      ev.data_pins = '0;
      ev.en_pin    = 1'b0;
      ev.hold_us   = INIT_WAIT_US;
    end else if (init_mode_r && cmd.step < INIT_BYTE_BASE) begin
      // mode nibbles
      ev.data_pins = MODE_NIBBLE[mstep[2:1]];
      ev.en_pin    = ~mstep[0];
      ev.hold_us   = mstep[0] ? (16'(nibble_settle_r) + MODE_EXTRA_US[mstep[2:1]])
                              : 16'(enable_pulse_r);
    end else begin
    end
  end

  assign status.ev_last = ev.last;

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= ev;
    end
  end

  assign out_item = out_r;

endmodule

// ===== rtl/char_lcd_nibble_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns byte-write and power-up requests into timed pin events for a
// character LCD on a 4-bit bus.
// ----------------------------------------------------------------------------
// A byte write yields four pin event beats (high nibble pulse and settle,
// then low nibble pulse and settle); an init request yields 25 beats of the
// fixed power-up sequence, with last set on the final one. Once a request is
// accepted, the controller produces one event beat per cycle into a single
// output register while the sink takes the beats; a beat that the sink holds
// off stalls the run until it is taken. The next request is accepted in the
// cycle after the final beat of the current run is loaded into the output
// register, while that beat may still wait for the sink. Configuration writes
// are always ready and should be made only while no run is in progress;
// writes to an index past the third register are ignored.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer
  import clnws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_fire;

  // configuration beats are taken every cycle
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  clnws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  clnws_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_fire  (cfg_fire),
    .cfg_index (cfg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .in_item   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_data)
  );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character LCD nibble write sequencer.
// Requests go in through a queue-fed driver, and the pin event beats that come
// out are checked one field at a time against a predictor. The predictor keeps
// its own copy of the timing registers. Register writes are made only while
// the block is drained. Random gaps on both channels stall requests and the
// beats of a run, and some phases run with no gaps at all.
// ----------------------------------------------------------------------------
module tb;
  import clnws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor copy of the timing registers
  logic [7:0]  pulse_us = ENABLE_PULSE_RST;
  logic [9:0]  settle_us = NIBBLE_SETTLE_RST;
  logic [9:0]  gap_us = BYTE_GAP_RST;

  in_item_t    request_queue[$];
  out_item_t   pin_events_due[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          idling = 1'b1;

  char_lcd_nibble_write_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(24, 8);
  endfunction

  function automatic in_item_t make_req(logic func, logic [7:0] value, logic sel);
    in_item_t req;
    req.func = func;
    req.value = value;
    req.reg_select = sel;
    return req;
  endfunction

  function automatic in_item_t rand_request();
    in_item_t req;
    req.func = ($urandom_range(99) < 8) ? FUNC_INIT : FUNC_WRITE;
    req.value = 8'($urandom_range(255));
    req.reg_select = 1'($urandom_range(1));
    return req;
  endfunction

  // expected pin events
  task automatic push_event(logic rs, logic [3:0] nib, logic en, logic [15:0] hold);
    out_item_t ev;
    ev.rs_pin = rs;
    ev.data_pins = nib;
    ev.en_pin = en;
    ev.hold_us = hold;
    ev.last = 1'b0;
    pin_events_due.push_back(ev);
  endtask

  // enable-high pulse, then enable-low settle
  task automatic push_nibble(logic rs, logic [3:0] nib, logic [15:0] extra);
    push_event(rs, nib, 1'b1, {8'd0, pulse_us});
    push_event(rs, nib, 1'b0, {6'd0, settle_us} + extra);
  endtask

  task automatic push_byte(logic rs, logic [7:0] b, logic [15:0] tail);
    push_nibble(rs, b[7:4], {6'd0, gap_us});
    push_nibble(rs, b[3:0], {6'd0, gap_us} + tail);
  endtask

  task automatic predict_pin_events(in_item_t req);
    out_item_t ev;
    if (req.func == FUNC_INIT) begin
      // power-up: long wait, mode nibbles, then setup bytes
      push_event(1'b0, 4'h0, 1'b0, INIT_WAIT_US);
      for (int i = 0; i < 4; i++) push_nibble(1'b0, MODE_NIBBLE[i], MODE_EXTRA_US[i]);
      for (int i = 0; i < 4; i++) push_byte(1'b0, INIT_BYTES[i], INIT_TAIL_US);
    end else begin
      push_byte(req.reg_select, req.value, 16'd0);
    end
    ev = pin_events_due.pop_back();
    ev.last = 1'b1;
    pin_events_due.push_back(ev);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_event(out_item_t got);
    out_item_t want;
    if (pin_events_due.size() == 0) begin
      report_mismatch("beat with nothing due, hold_us", got.hold_us, 16'd0);
      return;
    end
    want = pin_events_due.pop_front();
    if (got.rs_pin !== want.rs_pin)
      report_mismatch("rs_pin", 16'(got.rs_pin), 16'(want.rs_pin));
    if (got.data_pins !== want.data_pins)
      report_mismatch("data_pins", 16'(got.data_pins), 16'(want.data_pins));
    if (got.en_pin !== want.en_pin)
      report_mismatch("en_pin", 16'(got.en_pin), 16'(want.en_pin));
    if (got.hold_us !== want.hold_us) report_mismatch("hold_us", got.hold_us, want.hold_us);
    if (got.last !== want.last)
      report_mismatch("last", 16'(got.last), 16'(want.last));
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) predict_pin_events(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= request_queue.pop_front();
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // event monitor and sink stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) check_event(out_data);
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[char_lcd_nibble_write_sequencer] ERROR");
      $finish;
    end
  end

  // wait until every queued request is taken and every event has come back,
  // looking mid-cycle so the driver's updates have settled
  task automatic drain();
    while (request_queue.size() > 0 || in_valid || pin_events_due.size() > 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENABLE_PULSE:  pulse_us = val[7:0];
      CFG_NIBBLE_SETTLE: settle_us = val[9:0];
      CFG_BYTE_GAP:      gap_us = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [15:0] pulse, logic [15:0] settle, logic [15:0] gap);
    write_reg(CFG_ENABLE_PULSE, pulse);
    write_reg(CFG_NIBBLE_SETTLE, settle);
    write_reg(CFG_BYTE_GAP, gap);
  endtask

  task automatic random_phase(int n);
    repeat (n) request_queue.push_back(rand_request());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: byte extremes, both selects, init back to back
    request_queue.push_back(make_req(FUNC_WRITE, 8'h00, 1'b0));
    request_queue.push_back(make_req(FUNC_WRITE, 8'hFF, 1'b1));
    request_queue.push_back(make_req(FUNC_WRITE, 8'hA5, 1'b1));
    request_queue.push_back(make_req(FUNC_WRITE, 8'h5A, 1'b0));
    request_queue.push_back(make_req(FUNC_INIT, 8'hFF, 1'b1));
    request_queue.push_back(make_req(FUNC_WRITE, 8'h0F, 1'b0));
    request_queue.push_back(make_req(FUNC_WRITE, 8'hF0, 1'b1));
    request_queue.push_back(make_req(FUNC_INIT, 8'h00, 1'b0));
    request_queue.push_back(make_req(FUNC_INIT, 8'h3C, 1'b1));
    drain();

    // widest timing, settle and gap at full 10 bits
    set_timing(16'd255, 16'd1023, 16'd1023);
    request_queue.push_back(make_req(FUNC_INIT, 8'h00, 1'b0));
    request_queue.push_back(make_req(FUNC_WRITE, 8'hFF, 1'b1));
    request_queue.push_back(make_req(FUNC_WRITE, 8'h00, 1'b0));
    drain();

    // zero pulse width and zero settle and gap
    set_timing(16'd0, 16'd0, 16'd0);
    // unused index must not disturb anything
    write_reg(CFG_UNUSED, 16'hFFFF);
    request_queue.push_back(make_req(FUNC_INIT, 8'h81, 1'b1));
    request_queue.push_back(make_req(FUNC_WRITE, 8'h81, 1'b1));
    drain();

    // random phases, upper data bits carry garbage
    set_timing(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
               16'($urandom_range(16'hFFFF)));
    random_phase(60);

    idling = 1'b0;
    set_timing(16'd1, 16'd50, 16'd200);
    random_phase(50);

    idling = 1'b1;
    set_timing(16'($urandom_range(255, 1)), 16'($urandom_range(1000)),
               16'($urandom_range(1000)));
    random_phase(60);

    set_timing(16'd255, 16'd1000, 16'd0);
    random_phase(50);

    idling = 1'b0;
    set_timing(16'($urandom_range(255)), 16'($urandom_range(1023)),
               16'($urandom_range(1023)));
    random_phase(50);

    idling = 1'b1;
    set_timing(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
               16'($urandom_range(16'hFFFF)));
    random_phase(46);

    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("[char_lcd_nibble_write_sequencer] OK");
    end else begin
      $display("[char_lcd_nibble_write_sequencer] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/clnws_pkg.sv
rtl/clnws_ctrl.sv
rtl/clnws_datapath.sv
rtl/char_lcd_nibble_write_sequencer.sv
bench/tb.sv
